[rtl/fir_pkg.sv]
// Shared constants and types for the streaming FIR filter.
package fir_pkg;

    localparam int MAX_TAPS     = 64;
    localparam int TAP_AW       = $clog2(MAX_TAPS);
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
    localparam int COUNT_W      = 7;
    localparam int PROD_W       = 2 * SAMPLE_WIDTH;
    localparam int ACC_W        = PROD_W + TAP_AW + 1;

    localparam logic [COUNT_W-1:0] TAPS_RESET = COUNT_W'(64);

    typedef enum logic [1:0] {
        ITEM_SAMPLE = 2'd0,
        ITEM_COEFF  = 2'd1
    } fir_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } fir_state_t;

endpackage

[rtl/fir_if.sv]
// Stream interfaces for the FIR filter input items and results.
interface fir_in_if
    import fir_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic        [TAP_AW-1:0]       tap_index;
    logic signed [SAMPLE_WIDTH-1:0] value;

    modport source (output valid, output kind, output tap_index, output value, input ready);
    modport sink   (input valid, input kind, input tap_index, input value, output ready);
endinterface

interface fir_out_if
    import fir_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           saturated;

    modport source (output valid, output filtered, output saturated, input ready);
    modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

[rtl/fir_filter_stream.sv]
// Direct-form FIR filter with delay line and taps in synchronous memories.
// A sample walks N taps in the issue state (skipped if N is 0), N = active taps (clipped to 64),
// then drain and finish form the registered result; one multiply-accumulate walks a tap a cycle.
// Items are taken only while idle, so a new sample waits until the last result is loaded.
// Reset: asynchronous, active low; delay line and taps read as zero until written,
// through per-entry valid bits, and active taps returns to 64. No clearing pass is needed.
module fir_filter_stream
    import fir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    fir_in_if.sink             samples,
    fir_out_if.source          results
);

    localparam int RND_W = ACC_W + 1;
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1 << (FRAC_BITS - 1));

    fir_state_t state_reg, state_next;

    logic [COUNT_W-1:0] active_taps_reg;
    logic [TAP_AW-1:0]  newest_pos_reg;
    logic [TAP_AW-1:0]  cnt_reg, cnt_next;

    logic signed [SAMPLE_WIDTH-1:0] delay_mem [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] coeff_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]            delay_vld_reg;
    logic [MAX_TAPS-1:0]            coeff_vld_reg;

    logic signed [SAMPLE_WIDTH-1:0] delay_rd_reg, coeff_rd_reg;
    logic                           delay_rd_ok_reg, coeff_rd_ok_reg;
    logic                           rd_vld_reg, prod_vld_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;

    logic                           out_valid_reg, out_sat_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_filtered_reg;

    logic in_fire, sample_fire, coeff_fire;
    logic issue, fin_load;
    logic [COUNT_W-1:0] n_eff;
    logic [COUNT_W-1:0] n_last;
    logic [TAP_AW-1:0]  write_pos;
    logic [TAP_AW-1:0]  read_slot;
    logic signed [SAMPLE_WIDTH-1:0] delay_q, coeff_q;
    logic signed [RND_W-1:0]        rounded, shifted;
    logic signed [SAMPLE_WIDTH-1:0] clip_value;
    logic                           clip_flag;

    assign in_fire     = samples.valid && samples.ready;
    assign sample_fire = in_fire && (samples.kind == ITEM_SAMPLE[0]);
    assign coeff_fire  = in_fire && (samples.kind == ITEM_COEFF[0]);

    assign n_eff     = (active_taps_reg > COUNT_W'(MAX_TAPS)) ? COUNT_W'(MAX_TAPS)
                                                              : active_taps_reg;
    assign n_last    = n_eff - COUNT_W'(1);
    assign write_pos = newest_pos_reg + TAP_AW'(1);
    // The newest sample sits at newest_pos_reg once the walk starts.
    assign read_slot = newest_pos_reg - cnt_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (sample_fire)
                begin
                    state_next = (n_eff == '0) ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (cnt_reg == n_last[TAP_AW-1:0])
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + TAP_AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and control decode.
    always_comb
    begin
        samples.ready = 1'b0;
        issue         = 1'b0;
        fin_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:   samples.ready = 1'b1;
            ST_ISSUE:  issue = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: fin_load = !out_valid_reg || results.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            active_taps_reg <= TAPS_RESET;
            newest_pos_reg  <= '0;
            delay_vld_reg   <= '0;
            coeff_vld_reg   <= '0;
            rd_vld_reg      <= 1'b0;
            prod_vld_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if (cfg_we)
            begin
                active_taps_reg <= cfg_wdata;
            end
            if (sample_fire)
            begin
                newest_pos_reg           <= write_pos;
                delay_vld_reg[write_pos] <= 1'b1;
            end
            if (coeff_fire)
            begin
                coeff_vld_reg[samples.tap_index] <= 1'b1;
            end
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            delay_mem[write_pos] <= samples.value;
        end
        delay_rd_reg    <= delay_mem[read_slot];
        delay_rd_ok_reg <= delay_vld_reg[read_slot];
    end

    always_ff @(posedge clk)
    begin
        if (coeff_fire)
        begin
            coeff_mem[samples.tap_index] <= samples.value;
        end
        coeff_rd_reg    <= coeff_mem[cnt_reg];
        coeff_rd_ok_reg <= coeff_vld_reg[cnt_reg];
    end

    assign delay_q = delay_rd_ok_reg ? delay_rd_reg : '0;
    assign coeff_q = coeff_rd_ok_reg ? coeff_rd_reg : '0;

    // Multiply stage, then accumulate stage.
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= delay_q * coeff_q;
        end
        if (sample_fire)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // Round half up, then clip to the sample range.
    assign rounded = {acc_reg[ACC_W-1], acc_reg} + RND_HALF;
    assign shifted = rounded >>> FRAC_BITS;

    always_comb
    begin
        clip_flag = 1'b0;
        priority if (shifted > SAT_HI)
        begin
            clip_value = SAT_HI[SAMPLE_WIDTH-1:0];
            clip_flag  = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            clip_value = SAT_LO[SAMPLE_WIDTH-1:0];
            clip_flag  = 1'b1;
        end
        else
        begin
            clip_value = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            out_filtered_reg <= clip_value;
            out_sat_reg      <= clip_flag;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.filtered  = out_filtered_reg;
    assign results.saturated = out_sat_reg;

    a_read_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_ISSUE))
        else $error("tap read without an issue cycle");

    a_finish_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("result formed while products are still in flight");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> ({1'b0, cnt_reg} < n_eff))
        else $error("tap counter ran past the active taps");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a finished sum");

endmodule

[verif/fir_filter_stream_tb.sv]
// Self-checking testbench for the streaming FIR filter: directed and random items, varied stalls.
module fir_filter_stream_tb
    import fir_pkg::*;
();

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 1500;
    localparam int RANDOM_ITEMS  = 75;
    localparam int NUM_PHASES    = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] filtered;
        logic                           saturated;
    } fir_output_t;

    // Holds a private copy of the filter state and the outputs still owed by the block.
    class fir_tracker;
        logic signed [SAMPLE_WIDTH-1:0] history[MAX_TAPS];
        logic signed [SAMPLE_WIDTH-1:0] taps_mem[MAX_TAPS];
        int unsigned                    newest;
        int unsigned                    tap_count;
        fir_output_t                    owed_outputs[$];
        int                             errors;

        function new();
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                history[i]  = '0;
                taps_mem[i] = '0;
            end
            newest    = 0;
            tap_count = TAPS_RESET;
            errors    = 0;
        endfunction

        function void set_tap_count(logic [COUNT_W-1:0] count);
            tap_count = count;
        endfunction

        function int outstanding();
            return owed_outputs.size();
        endfunction

        // The accumulator is far wider than 64 products of Q1.15 values need,
        // so the sum here cannot reach the 64-bit limits.
        function fir_output_t filter_newest();
            fir_output_t res;
            longint      acc;
            longint      rounded;
            int unsigned n;
            int unsigned slot;
            acc = 0;
            n = (tap_count > MAX_TAPS) ? MAX_TAPS : tap_count;
            for (int unsigned i = 0; i < n; i++)
            begin
                slot = (newest + MAX_TAPS - i) % MAX_TAPS;
                acc += longint'(history[slot]) * longint'(taps_mem[i]);
            end
            if (n == 0)
                rounded = 0;
            else
                rounded = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            res.saturated = 1'b0;
            if (rounded > (longint'(1) << FRAC_BITS) - 1)
            begin
                rounded       = (longint'(1) << FRAC_BITS) - 1;
                res.saturated = 1'b1;
            end
            else if (rounded < -(longint'(1) << FRAC_BITS))
            begin
                rounded       = -(longint'(1) << FRAC_BITS);
                res.saturated = 1'b1;
            end
            res.filtered = rounded[SAMPLE_WIDTH-1:0];
            return res;
        endfunction

        function void note_item(fir_kind_t kind, logic [TAP_AW-1:0] tap,
                                logic signed [SAMPLE_WIDTH-1:0] val);
            if (kind == ITEM_COEFF)
            begin
                taps_mem[tap] = val;
            end
            else
            begin
                newest = (newest + 1) % MAX_TAPS;
                history[newest] = val;
                owed_outputs.push_back(filter_newest());
            end
        endfunction

        function void check_output(logic signed [SAMPLE_WIDTH-1:0] filtered, logic saturated);
            fir_output_t exp_out;
            if (owed_outputs.size() == 0)
            begin
                if (errors < REPORT_LIMIT)
                    $display("unexpected result: filtered %0d saturated %0b", filtered, saturated);
                errors++;
                return;
            end
            exp_out = owed_outputs.pop_front();
            if (filtered !== exp_out.filtered || saturated !== exp_out.saturated)
            begin
                if (errors < REPORT_LIMIT)
                    $display("result mismatch: expected filtered %0d saturated %0b, got %0d %0b",
                             exp_out.filtered, exp_out.saturated, filtered, saturated);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    fir_in_if  samples_ch();
    fir_out_if results_ch();

    fir_tracker sb;
    int         send_idle_pct;
    int         stall_pct;
    int         hold_reqs;
    int         cycles;

    fir_filter_stream u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (samples_ch),
        .results   (results_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("fir_filter_stream_tb NOT OK");
                $finish;
            end
        end
    end

    // Result side: checks each transfer and decides ready for the next cycle.
    // A hold-off request keeps ready low for a long stretch so the block backs up.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results_ch.valid && results_ch.ready)
                sb.check_output(results_ch.filtered, results_ch.saturated);
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else
            begin
                results_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_WIDTH'($signed($urandom_range(512)) - 256);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // Mostly scaled-down taps so that many sums stay in range; some full-scale ones.
    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_coeff();
        logic signed [SAMPLE_WIDTH-1:0] raw;
        raw = SAMPLE_WIDTH'($urandom);
        if ($urandom_range(3) == 0)
            return raw;
        return raw >>> $urandom_range(10, 5);
    endfunction

    task automatic send_item(input fir_kind_t kind, input logic [TAP_AW-1:0] tap,
                             input logic signed [SAMPLE_WIDTH-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid     <= 1'b1;
        samples_ch.kind      <= (kind == ITEM_COEFF);
        samples_ch.tap_index <= tap;
        samples_ch.value     <= val;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        sb.note_item(kind, tap, val);
    endtask

    // A coefficient write yields no result, so after the last result the block is
    // given a full sample latency before it is treated as idle.
    task automatic wait_quiet();
        samples_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tap_count(input logic [COUNT_W-1:0] count);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_tap_count(count);
    endtask

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(7) == 0)
                send_item(ITEM_COEFF, TAP_AW'($urandom_range(MAX_TAPS - 1)), rand_coeff());
            else
                send_item(ITEM_SAMPLE, TAP_AW'($urandom_range(MAX_TAPS - 1)), rand_sample());
        end
    endtask

    task automatic directed_items();
        // All taps are zero after reset, so the first output is zero.
        send_item(ITEM_SAMPLE, 6'd63, 16'sh7FFF);
        send_item(ITEM_COEFF,  6'd0,  16'sh7FFF);
        send_item(ITEM_COEFF,  6'd1,  16'sh8000);
        send_item(ITEM_COEFF,  6'd63, 16'sh7FFF);
        send_item(ITEM_SAMPLE, 6'd0,  16'sh7FFF);
        send_item(ITEM_SAMPLE, 6'd63, 16'sh8000);
        send_item(ITEM_SAMPLE, 6'd0,  16'sh7FFF);
        // The most negative value squared clips at the positive limit.
        send_item(ITEM_COEFF,  6'd0,  16'sh8000);
        send_item(ITEM_SAMPLE, 6'd0,  16'sh8000);
        send_item(ITEM_SAMPLE, 6'd0,  16'sh8000);
        // Only tap 0 stays nonzero, at the smallest step, to probe rounding.
        send_item(ITEM_COEFF,  6'd0,  16'sh0001);
        send_item(ITEM_COEFF,  6'd1,  16'sh0000);
        send_item(ITEM_COEFF,  6'd63, 16'sh0000);
        // Exact halves round toward positive infinity on both signs.
        send_item(ITEM_SAMPLE, 6'd0,  16'sh4000);
        send_item(ITEM_SAMPLE, 6'd0,  -16'sh4000);
        send_item(ITEM_SAMPLE, 6'd0,  16'sh3FFF);
        send_item(ITEM_SAMPLE, 6'd0,  -16'sh4001);
        send_item(ITEM_SAMPLE, 6'd0,  16'sh0000);
    endtask

    initial
    begin
        int leftover;
        sb = new();
        send_idle_pct = 0;
        stall_pct     <= 0;
        hold_reqs     <= 0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        samples_ch.valid     <= 1'b0;
        samples_ch.kind      <= 1'b0;
        samples_ch.tap_index <= '0;
        samples_ch.value     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1: begin send_idle_pct = 67; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 67; end
                3: begin send_idle_pct = 29; stall_pct <= 29; end
                5: begin send_idle_pct = 67; stall_pct <= 0;  end
                6: begin send_idle_pct = 29; stall_pct <= 29; end
                7: begin send_idle_pct = 0;  stall_pct <= 67; end
                default: begin send_idle_pct = 0; stall_pct <= 0; end
            endcase
            if (phase != 0)
            begin
                wait_quiet();
                case (phase)
                    1: write_tap_count(COUNT_W'(1));
                    2: write_tap_count(COUNT_W'(0));
                    3: write_tap_count(COUNT_W'(127));
                    4: write_tap_count(COUNT_W'(65));
                    5: write_tap_count(COUNT_W'($urandom_range(63, 2)));
                    6: write_tap_count(COUNT_W'(64));
                    default: write_tap_count(COUNT_W'($urandom_range(64, 1)));
                endcase
            end
            if (phase == 0)
                directed_items();
            if (phase == 0 || phase == 4)
                hold_reqs <= hold_reqs + 1;
            random_items(RANDOM_ITEMS);
        end

        wait_quiet();
        leftover = sb.outstanding();
        if (sb.errors == 0 && leftover == 0)
        begin
            $display("fir_filter_stream_tb OK");
        end
        else
        begin
            $display("fir_filter_stream_tb NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/fir_pkg.sv
rtl/fir_if.sv
rtl/fir_filter_stream.sv
verif/fir_filter_stream_tb.sv
